@@ hw/rtl/jsu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types for the JSON string unescaper: result kinds, error codes,
// decoder modes and the result group handed from the decoder to the buffer.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Kind of one result
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } jsu_kind_e;

  // Error codes reported with KIND_ERROR
  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_UNTERMINATED = 3'd1,
    ERR_BAD_HEX      = 3'd2,
    ERR_BS_EXPECTED  = 3'd3,
    ERR_U_EXPECTED   = 3'd4,
    ERR_BAD_LOW_SUR  = 3'd5,
    ERR_LONE_LOW_SUR = 3'd6
  } jsu_err_e;

  // Decoder modes
  typedef enum logic [2:0] {
    MODE_PLAIN   = 3'd0,
    MODE_ESC     = 3'd1,
    MODE_HEX1    = 3'd2,
    MODE_WANT_BS = 3'd3,
    MODE_WANT_U  = 3'd4,
    MODE_HEX2    = 3'd5
  } jsu_mode_e;

  // Max results caused by one input byte
  localparam int unsigned GroupBytes = 4;
  localparam int unsigned GroupIdxW  = $clog2(GroupBytes);

  // All results caused by one input byte
  typedef struct packed {
    logic [GroupBytes-1:0][7:0] bytes;   // data bytes, entry 0 first
    logic [GroupIdxW-1:0]       n_last;  // index of the final result
    jsu_kind_e                  kind;
    jsu_err_e                   err;
  } jsu_group_t;

endpackage
`default_nettype wire

@@ hw/rtl/jsu_decode.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_decode
// Escape and \u decoder state machine. Takes one byte per transfer and
// produces the group of results that byte causes, including UTF-8 encoding
// of \u code points and surrogate pairs.
// ----------------------------------------------------------------------------
module jsu_decode (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [7:0]       byte_i,
  output jsu_pkg::jsu_group_t   group_o,
  output logic                  emit_o
);

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChB      = 8'h62;
  localparam logic [7:0] ChF      = 8'h66;
  localparam logic [7:0] ChN      = 8'h6E;
  localparam logic [7:0] ChR      = 8'h72;
  localparam logic [7:0] ChT      = 8'h74;
  localparam logic [7:0] ChU      = 8'h75;

  localparam logic [5:0] HighSurTop = 6'b110110;
  localparam logic [5:0] LowSurTop  = 6'b110111;

  // Returns {valid, value} for an ASCII hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  // Encode a code point as a UTF-8 group
  function automatic jsu_pkg::jsu_group_t utf8_encode(input logic [20:0] cp);
    jsu_pkg::jsu_group_t g;
    g        = '0;
    g.kind   = jsu_pkg::KIND_DATA;
    g.err    = jsu_pkg::ERR_NONE;
    if (cp <= 21'h7F) begin
      g.bytes[0] = cp[7:0];
      g.n_last   = 2'd0;
    end else if (cp <= 21'h7FF) begin
      g.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
      g.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
      g.n_last   = 2'd1;
    end else if (cp <= 21'hFFFF) begin
      g.bytes[0] = 8'hE0 | {4'b0000, cp[15:12]};
      g.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
      g.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
      g.n_last   = 2'd2;
    end else begin
      g.bytes[0] = 8'hF0 | {5'b00000, cp[20:18]};
      g.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
      g.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
      g.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
      g.n_last   = 2'd3;
    end
    return g;
  endfunction

  jsu_pkg::jsu_mode_e mode_q, mode_d;
  logic [1:0]         cnt_q, cnt_d;
  logic [15:0]        acc_q, acc_d;
  logic [9:0]         hs_q, hs_d;

  logic [4:0]  hex;
  logic [15:0] code;
  logic        code_high;
  logic        code_low;
  logic [20:0] pair_cp;

  assign hex       = hex_value(byte_i);
  assign code      = {acc_q[11:0], hex[3:0]};
  assign code_high = (code[15:10] == HighSurTop);
  assign code_low  = (code[15:10] == LowSurTop);
  assign pair_cp   = {1'b0, hs_q, code[9:0]} + 21'h10000;

  // Next state
  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    hs_d   = hs_q;
    unique case (mode_q)
      jsu_pkg::MODE_ESC: begin
        if (byte_i == ChNul) begin
          mode_d = jsu_pkg::MODE_PLAIN;
          cnt_d  = 2'd0;
          acc_d  = 16'd0;
          hs_d   = 10'd0;
        end else if (byte_i == ChU) begin
          mode_d = jsu_pkg::MODE_HEX1;
          cnt_d  = 2'd0;
          acc_d  = 16'd0;
        end else begin
          mode_d = jsu_pkg::MODE_PLAIN;
        end
      end
      jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
        if (!hex[4]) begin
          mode_d = jsu_pkg::MODE_PLAIN;
          cnt_d  = 2'd0;
          acc_d  = 16'd0;
          hs_d   = 10'd0;
        end else if (cnt_q != 2'd3) begin
          acc_d = code;
          cnt_d = cnt_q + 2'd1;
        end else if (mode_q == jsu_pkg::MODE_HEX1 && code_high) begin
          hs_d   = code[9:0];
          acc_d  = 16'd0;
          cnt_d  = 2'd0;
          mode_d = jsu_pkg::MODE_WANT_BS;
        end else begin
          // Code point done or rejected: back to plain, all cleared
          mode_d = jsu_pkg::MODE_PLAIN;
          cnt_d  = 2'd0;
          acc_d  = 16'd0;
          hs_d   = 10'd0;
        end
      end
      jsu_pkg::MODE_WANT_BS: begin
        if (byte_i == ChBslash) begin
          mode_d = jsu_pkg::MODE_WANT_U;
        end else begin
          mode_d = jsu_pkg::MODE_PLAIN;
          cnt_d  = 2'd0;
          acc_d  = 16'd0;
          hs_d   = 10'd0;
        end
      end
      jsu_pkg::MODE_WANT_U: begin
        if (byte_i == ChU) begin
          mode_d = jsu_pkg::MODE_HEX2;
          cnt_d  = 2'd0;
          acc_d  = 16'd0;
        end else begin
          mode_d = jsu_pkg::MODE_PLAIN;
          cnt_d  = 2'd0;
          acc_d  = 16'd0;
          hs_d   = 10'd0;
        end
      end
      default: begin
        // Plain mode; unused codes behave the same
        if (byte_i == ChNul || byte_i == ChQuote) begin
          mode_d = jsu_pkg::MODE_PLAIN;
          cnt_d  = 2'd0;
          acc_d  = 16'd0;
          hs_d   = 10'd0;
        end else if (byte_i == ChBslash) begin
          mode_d = jsu_pkg::MODE_ESC;
        end else begin
          mode_d = jsu_pkg::MODE_PLAIN;
        end
      end
    endcase
  end

  // Outputs: result group for this byte
  always_comb begin
    emit_o       = 1'b0;
    group_o      = '0;
    group_o.kind = jsu_pkg::KIND_DATA;
    group_o.err  = jsu_pkg::ERR_NONE;
    unique case (mode_q)
      jsu_pkg::MODE_ESC: begin
        emit_o = 1'b1;
        case (byte_i) inside
          ChNul: begin
            group_o.kind = jsu_pkg::KIND_ERROR;
            group_o.err  = jsu_pkg::ERR_UNTERMINATED;
          end
          ChQuote, ChBslash, ChSlash: group_o.bytes[0] = byte_i;
          ChB: group_o.bytes[0] = 8'h08;
          ChF: group_o.bytes[0] = 8'h0C;
          ChN: group_o.bytes[0] = 8'h0A;
          ChR: group_o.bytes[0] = 8'h0D;
          ChT: group_o.bytes[0] = 8'h09;
          ChU: emit_o = 1'b0;
          default: begin
            // Unknown escape: pass backslash and character
            group_o.bytes[0] = ChBslash;
            group_o.bytes[1] = byte_i;
            group_o.n_last   = 2'd1;
          end
        endcase
      end
      jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
        if (!hex[4]) begin
          emit_o       = 1'b1;
          group_o.kind = jsu_pkg::KIND_ERROR;
          group_o.err  = jsu_pkg::ERR_BAD_HEX;
        end else if (cnt_q == 2'd3) begin
          if (mode_q == jsu_pkg::MODE_HEX1) begin
            if (code_low) begin
              emit_o       = 1'b1;
              group_o.kind = jsu_pkg::KIND_ERROR;
              group_o.err  = jsu_pkg::ERR_LONE_LOW_SUR;
            end else if (!code_high) begin
              emit_o  = 1'b1;
              group_o = utf8_encode({5'd0, code});
            end
          end else if (!code_low) begin
            emit_o       = 1'b1;
            group_o.kind = jsu_pkg::KIND_ERROR;
            group_o.err  = jsu_pkg::ERR_BAD_LOW_SUR;
          end else begin
            emit_o  = 1'b1;
            group_o = utf8_encode(pair_cp);
          end
        end
      end
      jsu_pkg::MODE_WANT_BS: begin
        if (byte_i != ChBslash) begin
          emit_o       = 1'b1;
          group_o.kind = jsu_pkg::KIND_ERROR;
          group_o.err  = jsu_pkg::ERR_BS_EXPECTED;
        end
      end
      jsu_pkg::MODE_WANT_U: begin
        if (byte_i != ChU) begin
          emit_o       = 1'b1;
          group_o.kind = jsu_pkg::KIND_ERROR;
          group_o.err  = jsu_pkg::ERR_U_EXPECTED;
        end
      end
      default: begin
        if (byte_i == ChNul) begin
          emit_o       = 1'b1;
          group_o.kind = jsu_pkg::KIND_ERROR;
          group_o.err  = jsu_pkg::ERR_UNTERMINATED;
        end else if (byte_i == ChQuote) begin
          emit_o       = 1'b1;
          group_o.kind = jsu_pkg::KIND_END;
        end else if (byte_i != ChBslash) begin
          emit_o           = 1'b1;
          group_o.bytes[0] = byte_i;
        end
      end
    endcase
  end

  // Advance decoder state on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jsu_pkg::MODE_PLAIN;
      cnt_q  <= 2'd0;
      acc_q  <= 16'd0;
      hs_q   <= 10'd0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
      hs_q   <= hs_d;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/json_string_unescape_utf8.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// JSON string body unescaper with \u and surrogate pair to UTF-8 conversion.
// ----------------------------------------------------------------------------
// One input byte is taken per cycle while the input is not stalled and is
// decoded in the same cycle; its results (0 to 4) are written as one group
// into a two-group result buffer, and results leave the registered buffer
// one per cycle while the output is not stalled. An input byte is taken in
// every cycle in which the buffer has a free group slot, so plain text
// streams at one byte per cycle while the output is not stalled. The up to
// four UTF-8 bytes of a \u escape are absorbed by the buffer, and the input
// stalls only when both group slots are full.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      kind_o,
  output logic [2:0]      error_code_o,
  output logic            last_o
);

  jsu_pkg::jsu_group_t dec_group;
  logic                dec_emit;
  logic                in_xfer;
  logic                out_xfer;
  logic                push;
  logic                pop;

  jsu_pkg::jsu_group_t         slot_q [2];
  logic                        wr_q, wr_d;
  logic                        rd_q, rd_d;
  logic [1:0]                  cnt_q, cnt_d;
  logic [jsu_pkg::GroupIdxW-1:0] idx_q, idx_d;
  jsu_pkg::jsu_group_t         head;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  jsu_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_xfer),
    .byte_i   (in_byte_i),
    .group_o  (dec_group),
    .emit_o   (dec_emit)
  );

  // Result buffer control
  assign head         = slot_q[rd_q];
  assign out_valid_o  = (cnt_q != 2'd0);
  assign in_stall_o   = (cnt_q == 2'd2);
  assign last_o       = (idx_q == head.n_last);
  assign out_byte_o   = head.bytes[idx_q];
  assign kind_o       = head.kind;
  assign error_code_o = head.err;

  assign push = in_xfer && dec_emit;
  assign pop  = out_xfer && last_o;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
    idx_d = idx_q;
    if (out_xfer) begin
      idx_d = last_o ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
      idx_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  // Store the decoded group
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= dec_group;
    end
  end

  // Checks
  a_full_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("buffer full without a result on offer");

  a_marker_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != jsu_pkg::KIND_DATA) |-> last_o)
    else $error("end or error result not marked last");

  a_error_has_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == jsu_pkg::KIND_ERROR) |-> (error_code_o != jsu_pkg::ERR_NONE))
    else $error("error result without error code");

  a_pop_frees_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (cnt_q == $past(cnt_q) - 2'd1))
    else $error("group pop did not free a slot");

endmodule
`default_nettype wire
